FILE: rtl/core/sttt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sttt_pkg;

	localparam int DATA_W    = 32;
	localparam int PHASE_W   = 8;
	localparam int SLOT_W    = 4;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 3;
	localparam int MAX_TASKS = 16;
	localparam int MAX_FIRES = 16;
	localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_TICK   = 3'd1,
		OP_SCAN   = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_RELOAD = 3'd4,
		OP_PAUSE  = 3'd5,
		OP_RESUME = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 3'd0,
		ST_ACK       = 3'd1,
		ST_FIRED     = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5,
		ST_BAD_SLOT  = 3'd6,
		ST_DONE      = 3'd7
	} status_t;

	// Command travelling down the cell chain, with what it has gathered so far
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [SLOT_W-1:0] sel;
		logic [DATA_W-1:0] cb;
		logic [DATA_W-1:0] period;
		logic              en;
		logic [PHASE_W-1:0] phase;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic [DATA_W-1:0] hit_cb;
		logic [FIRE_W-1:0] fire_cnt;
	} pkt_t;

	// Fire report raised by the cell currently holding a scan
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] cb;
	} emit_t;

endpackage

`default_nettype wire

FILE: rtl/core/sttt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sttt_cell #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sttt_pkg::pkt_t  pkt_in,
	output sttt_pkg::pkt_t       pkt_out,
	output sttt_pkg::emit_t      emit
);

	localparam logic [sttt_pkg::SLOT_W-1:0] SLOT = IDX[sttt_pkg::SLOT_W-1:0];
	localparam bit ADDRESSABLE = (IDX < (1 << sttt_pkg::SLOT_W));

	logic                        used_q;
	logic                        en_q;
	logic [sttt_pkg::DATA_W-1:0] cd_q;
	logic [sttt_pkg::DATA_W-1:0] per_q;
	logic [sttt_pkg::DATA_W-1:0] cb_q;

	logic is_sel_op;
	logic add_take;
	logic tick_dec;
	logic fire;
	logic match;
	logic sel_hit;
	logic [sttt_pkg::DATA_W-1:0] start_cd;
	sttt_pkg::pkt_t nxt;

	always_comb begin
		is_sel_op = pkt_in.op == sttt_pkg::OP_RELOAD || pkt_in.op == sttt_pkg::OP_PAUSE
			|| pkt_in.op == sttt_pkg::OP_RESUME;
		// used cells form a prefix, so the first free cell is slot used_count
		add_take = pkt_in.valid && pkt_in.op == sttt_pkg::OP_ADD && !used_q && !pkt_in.hit;
		tick_dec = pkt_in.valid && pkt_in.op == sttt_pkg::OP_TICK && used_q && en_q
			&& cd_q != '0;
		fire = pkt_in.valid && pkt_in.op == sttt_pkg::OP_SCAN && used_q && en_q
			&& cd_q == '0 && pkt_in.fire_cnt < sttt_pkg::FIRE_W'(sttt_pkg::MAX_FIRES);
		match = pkt_in.valid && pkt_in.op == sttt_pkg::OP_LOOKUP && used_q && !pkt_in.hit
			&& cb_q == pkt_in.cb;
		sel_hit = pkt_in.valid && is_sel_op && ADDRESSABLE && pkt_in.sel == SLOT && used_q;

		start_cd = ({{(sttt_pkg::DATA_W - sttt_pkg::PHASE_W){1'b0}}, pkt_in.phase}
			> pkt_in.period) ? sttt_pkg::DATA_W'(1)
			: {{(sttt_pkg::DATA_W - sttt_pkg::PHASE_W){1'b0}}, pkt_in.phase};

		nxt = pkt_in;
		if (add_take || match || sel_hit) begin
			nxt.hit      = 1'b1;
			nxt.hit_slot = SLOT;
		end
		if (sel_hit) begin
			nxt.hit_cb = cb_q;
		end
		if (fire) begin
			nxt.fire_cnt = sttt_pkg::FIRE_W'(pkt_in.fire_cnt + 1'b1);
		end

		emit.valid = fire;
		emit.slot  = SLOT;
		emit.cb    = cb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_out <= '0;
		end else begin
			pkt_out <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			en_q   <= 1'b0;
		end else if (add_take) begin
			used_q <= 1'b1;
			en_q   <= pkt_in.en;
		end else if (sel_hit && pkt_in.op == sttt_pkg::OP_PAUSE) begin
			en_q <= 1'b0;
		end else if (sel_hit && pkt_in.op == sttt_pkg::OP_RESUME) begin
			en_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (add_take) begin
			per_q <= pkt_in.period;
			cb_q  <= pkt_in.cb;
			cd_q  <= start_cd;
		end else if (tick_dec) begin
			cd_q <= cd_q - 1'b1;
		end else if (fire || (sel_hit && pkt_in.op == sttt_pkg::OP_RELOAD)) begin
			cd_q <= per_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/software_timer_task_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic task timer table built as a chain of MAX_TASKS slot cells. An item
// is taken when start is high and busy is low; it then walks the chain one
// cell per clock, each cell acting on its own slot as the command passes
// (add, tick, scan, lookup, reload, pause, resume). busy stays high from the
// take until the command leaves the last cell, and the closing result sits on
// the ports in the same cycle that busy drops, so a new item can be taken only
// once the last one is through the chain; the wait is set by the length of the
// cell chain. Each result sits on the result ports for exactly one cycle,
// marked by strobe, and cannot be held off: the receiver must take it. A scan
// gives one fired result per firing slot, in slot order, as the command
// passes that slot, then a done result with last high; every other command
// gives one result with last high, and the undefined opcode gives none.
module software_timer_task_table_unit #(
	parameter int MAX_TASKS = sttt_pkg::MAX_TASKS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [sttt_pkg::OP_W-1:0]     opcode,
	input  wire logic [sttt_pkg::SLOT_W-1:0]   slot_index,
	input  wire logic [sttt_pkg::DATA_W-1:0]   callback_id,
	input  wire logic [sttt_pkg::DATA_W-1:0]   period_ms,
	input  wire logic                          start_enabled,
	input  wire logic [sttt_pkg::PHASE_W-1:0]  start_phase,
	output logic                               strobe,
	output logic [sttt_pkg::STATUS_W-1:0]      status,
	output logic [sttt_pkg::SLOT_W-1:0]        result_slot,
	output logic [sttt_pkg::DATA_W-1:0]        result_callback,
	output logic                               last
);

	// link[0] holds the accepted item; link[i+1] is the output of cell i
	sttt_pkg::pkt_t  link [MAX_TASKS+1];
	sttt_pkg::emit_t emits [MAX_TASKS];
	logic [MAX_TASKS:0] link_valid;

	logic busy_q;
	logic accept;
	sttt_pkg::pkt_t tail;
	sttt_pkg::pkt_t head_d;
	sttt_pkg::pkt_t head_q;

	// Collected fire report from whichever cell holds the scan
	logic                        emit_any;
	logic [sttt_pkg::SLOT_W-1:0] emit_slot;
	logic [sttt_pkg::DATA_W-1:0] emit_cb;

	// Final result once the command leaves the last cell
	logic                        fin_valid;
	sttt_pkg::status_t           fin_status;
	logic [sttt_pkg::SLOT_W-1:0] fin_slot;
	logic [sttt_pkg::DATA_W-1:0] fin_cb;

	logic                        strobe_q;
	sttt_pkg::status_t           status_q;
	logic [sttt_pkg::SLOT_W-1:0] slot_q;
	logic [sttt_pkg::DATA_W-1:0] cb_q;
	logic                        last_q;

	assign accept = start && !busy_q;
	assign tail   = link[MAX_TASKS];

	// Build the head packet from the ports, with nothing gathered yet
	always_comb begin
		head_d        = '0;
		head_d.valid  = accept;
		head_d.op     = sttt_pkg::op_t'(opcode);
		head_d.sel    = slot_index;
		head_d.cb     = callback_id;
		head_d.period = period_ms;
		head_d.en     = start_enabled;
		head_d.phase  = start_phase;
	end

	// Load the item into the head of the chain; drop the valid otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_d;
		end
	end

	assign link[0] = head_q;

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		sttt_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.pkt_in (link[g]),
			.pkt_out(link[g+1]),
			.emit   (emits[g])
		);
	end

	always_comb begin
		for (int i = 0; i <= MAX_TASKS; i++) begin
			link_valid[i] = link[i].valid;
		end
	end

	// Only one cell holds the command, so at most one report is raised
	always_comb begin
		emit_any  = 1'b0;
		emit_slot = '0;
		emit_cb   = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			emit_any  = emit_any | emits[i].valid;
			emit_slot = emit_slot | (emits[i].slot & {sttt_pkg::SLOT_W{emits[i].valid}});
			emit_cb   = emit_cb | (emits[i].cb & {sttt_pkg::DATA_W{emits[i].valid}});
		end
	end

	// Form the closing result from what the command gathered on its way
	always_comb begin
		fin_valid  = tail.valid;
		fin_status = sttt_pkg::ST_ACK;
		fin_slot   = '0;
		fin_cb     = '0;
		unique case (tail.op)
			sttt_pkg::OP_ADD: begin
				if (tail.hit) begin
					fin_status = sttt_pkg::ST_ADDED;
					fin_slot   = tail.hit_slot;
					fin_cb     = tail.cb;
				end else begin
					fin_status = sttt_pkg::ST_FULL;
				end
			end
			sttt_pkg::OP_TICK: begin
				fin_status = sttt_pkg::ST_ACK;
			end
			sttt_pkg::OP_SCAN: begin
				fin_status = sttt_pkg::ST_DONE;
			end
			sttt_pkg::OP_LOOKUP: begin
				if (tail.hit) begin
					fin_status = sttt_pkg::ST_FOUND;
					fin_slot   = tail.hit_slot;
					fin_cb     = tail.cb;
				end else begin
					fin_status = sttt_pkg::ST_NOT_FOUND;
				end
			end
			sttt_pkg::OP_RELOAD, sttt_pkg::OP_PAUSE, sttt_pkg::OP_RESUME: begin
				fin_slot = tail.sel;
				if (tail.hit) begin
					fin_status = sttt_pkg::ST_ACK;
					fin_cb     = tail.hit_cb;
				end else begin
					fin_status = sttt_pkg::ST_BAD_SLOT;
				end
			end
			default: begin
				// undefined opcode: no result
				fin_valid = 1'b0;
			end
		endcase
	end

	// Hold busy from accept until the command leaves the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (tail.valid) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_any || fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			status_q <= sttt_pkg::ST_FIRED;
			slot_q   <= emit_slot;
			cb_q     <= emit_cb;
			last_q   <= 1'b0;
		end else if (fin_valid) begin
			status_q <= fin_status;
			slot_q   <= fin_slot;
			cb_q     <= fin_cb;
			last_q   <= 1'b1;
		end
	end

	assign busy            = busy_q;
	assign strobe          = strobe_q;
	assign status          = status_q;
	assign result_slot     = slot_q;
	assign result_callback = cb_q;
	assign last            = last_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(link_valid) <= 1)
		else $error("more than one command in the cell chain");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(busy_q))
		else $error("result strobe without a command in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && link[0].valid)
		else $error("accepted item did not enter the chain");

	a_tail_release: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> !busy_q)
		else $error("busy held after the command left the chain");

	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_any && tail.valid))
		else $error("fire report and closing result in the same cycle");

endmodule

`default_nettype wire

FILE: tb/sv/software_timer_task_table_unit_tb.sv
`timescale 1ns / 1ps

module software_timer_task_table_unit_tb;
	import sttt_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 450;
	// Tail of the random part that runs back to back, with no idling at all
	localparam int CALM_ITEMS   = 80;
	// One item walks the whole cell chain; allow a few chain lengths at the end
	localparam int SETTLE_CYCLES = 3 * (MAX_TASKS + 1);
	localparam int REPORT_LIMIT  = 10;
	// Roughly 500 items run in about 150 us; allow well over ten times that
	localparam int TIMEOUT_NS    = 2_000_000;
	// The one opcode the block leaves undefined: accepted, but it gives no result
	localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  sel;
		logic [DATA_W-1:0]  cb;
		logic [DATA_W-1:0]  period;
		logic               en;
		logic [PHASE_W-1:0] phase;
	} command_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   cb;
		logic                last;
	} report_t;

	// Shadow copy of the task table: predicts every report an accepted item causes
	// and checks the reports the block gives against them, oldest first.
	class task_table_tracker;
		bit              slot_used [MAX_TASKS];
		bit              slot_on   [MAX_TASKS];
		bit [DATA_W-1:0] countdown [MAX_TASKS];
		bit [DATA_W-1:0] period    [MAX_TASKS];
		bit [DATA_W-1:0] callback  [MAX_TASKS];
		int unsigned     used_count;
		report_t         due_reports [$];
		int unsigned     mismatches;

		function void queue_report(status_t st, int unsigned slot, bit [DATA_W-1:0] cb,
				bit last);
			report_t r;
			r.status = st;
			r.slot   = slot[SLOT_W-1:0];
			r.cb     = cb;
			r.last   = last;
			due_reports.push_back(r);
		endfunction

		function void note_command(command_t c);
			int unsigned s;
			int unsigned fired;
			fired = 0;
			case (c.op)
				OP_ADD: begin
					if (used_count >= MAX_TASKS) begin
						queue_report(ST_FULL, 0, '0, 1'b1);
					end else begin
						s = used_count;
						slot_used[s] = 1'b1;
						slot_on[s]   = c.en;
						period[s]    = c.period;
						callback[s]  = c.cb;
						// a start phase beyond the period collapses to one tick
						countdown[s] = (DATA_W'(c.phase) > c.period) ? 1 : DATA_W'(c.phase);
						used_count++;
						queue_report(ST_ADDED, s, c.cb, 1'b1);
					end
				end
				OP_TICK: begin
					for (s = 0; s < MAX_TASKS; s++)
						if (slot_used[s] && slot_on[s] && countdown[s] != 0)
							countdown[s]--;
					queue_report(ST_ACK, 0, '0, 1'b1);
				end
				OP_SCAN: begin
					for (s = 0; s < MAX_TASKS && fired < MAX_FIRES; s++) begin
						if (slot_used[s] && slot_on[s] && countdown[s] == 0) begin
							countdown[s] = period[s];
							queue_report(ST_FIRED, s, callback[s], 1'b0);
							fired++;
						end
					end
					queue_report(ST_DONE, 0, '0, 1'b1);
				end
				OP_LOOKUP: begin
					// first match in insertion order wins
					for (s = 0; s < MAX_TASKS && fired == 0; s++) begin
						if (slot_used[s] && callback[s] == c.cb) begin
							queue_report(ST_FOUND, s, c.cb, 1'b1);
							fired = 1;
						end
					end
					if (fired == 0)
						queue_report(ST_NOT_FOUND, 0, '0, 1'b1);
				end
				OP_RELOAD, OP_PAUSE, OP_RESUME: begin
					s = 32'(c.sel);
					if (s >= used_count || !slot_used[s]) begin
						queue_report(ST_BAD_SLOT, s, '0, 1'b1);
					end else begin
						if (c.op == OP_RELOAD)
							countdown[s] = period[s];
						else if (c.op == OP_PAUSE)
							slot_on[s] = 1'b0;
						else
							slot_on[s] = 1'b1;
						queue_report(ST_ACK, s, callback[s], 1'b1);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(report_t got);
			report_t want;
			if (due_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result: status %0d slot %0d callback %h last %b",
						$realtime, got.status, got.slot, got.cb, got.last);
				return;
			end
			want = due_reports.pop_front();
			if (got.status !== want.status || got.slot !== want.slot ||
					got.cb !== want.cb || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch: expected status %0d slot %0d callback %h last %b",
						$realtime, want.status, want.slot, want.cb, want.last);
					$display("%0t: mismatch: got      status %0d slot %0d callback %h last %b",
						$realtime, got.status, got.slot, got.cb, got.last);
				end
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic [OP_W-1:0]     opcode        = '0;
	logic [SLOT_W-1:0]   slot_index    = '0;
	logic [DATA_W-1:0]   callback_id   = '0;
	logic [DATA_W-1:0]   period_ms     = '0;
	logic                start_enabled = 1'b0;
	logic [PHASE_W-1:0]  start_phase   = '0;
	logic                busy;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   result_slot;
	logic [DATA_W-1:0]   result_callback;
	logic                last;

	task_table_tracker slot_table = new();

	software_timer_task_table_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.slot_index     (slot_index),
		.callback_id    (callback_id),
		.period_ms      (period_ms),
		.start_enabled  (start_enabled),
		.start_phase    (start_phase),
		.strobe         (strobe),
		.status         (status),
		.result_slot    (result_slot),
		.result_callback(result_callback),
		.last           (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Take every strobed result at the rising edge; an unknown strobe counts as one
	always @(posedge clk) begin
		report_t got;
		if (arst_n && strobe !== 1'b0) begin
			got.status = status;
			got.slot   = result_slot;
			got.cb     = result_callback;
			got.last   = last;
			slot_table.check_result(got);
		end
	end

	function automatic command_t make_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sel,
			logic [DATA_W-1:0] cb, logic [DATA_W-1:0] period, logic en,
			logic [PHASE_W-1:0] phase);
		command_t c;
		c.op     = op;
		c.sel    = sel;
		c.cb     = cb;
		c.period = period;
		c.en     = en;
		c.phase  = phase;
		return c;
	endfunction

	// Present one item at the falling edge and hold it until the block takes it.
	// start is left high so a following item can go straight in; callers lower it.
	task automatic issue(input command_t c);
		opcode        <= c.op;
		slot_index    <= c.sel;
		callback_id   <= c.cb;
		period_ms     <= c.period;
		start_enabled <= c.en;
		start_phase   <= c.phase;
		start         <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		slot_table.note_command(c);
		@(negedge clk);
	endtask

	// Drop start and hold off until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		while (slot_table.due_reports.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		command_t    c;
		int unsigned pick;
		int unsigned gap;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table: lookup misses, scan gives only its done item, slot 0 is unused
		issue(make_command(OP_LOOKUP, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_SCAN, 4'hF, '1, '1, 1'b1, 8'hFF));
		issue(make_command(OP_RELOAD, 4'd0, 32'h0000_00A5, 32'd7, 1'b1, 8'd3));
		issue(make_command(OP_UNDEFINED, 4'hF, '1, '1, 1'b1, 8'hFF));
		// Zero period fires on every scan; widest period keeps the full phase;
		// a phase beyond the period becomes one; a duplicate id starts disabled
		issue(make_command(OP_ADD, 4'd0, '0, '0, 1'b1, '0));
		issue(make_command(OP_ADD, 4'd0, '1, '1, 1'b1, 8'hFF));
		issue(make_command(OP_ADD, 4'd0, 32'h0000_1234, 32'd3, 1'b1, 8'hFF));
		issue(make_command(OP_ADD, 4'd0, 32'h0000_1234, 32'd5, 1'b0, 8'd5));
		// Slot numbers at and beyond the fill level are unused
		issue(make_command(OP_PAUSE, 4'hF, '0, '0, 1'b0, '0));
		issue(make_command(OP_RESUME, 4'd4, '0, '0, 1'b0, '0));
		// Lookup returns the first of two equal ids
		issue(make_command(OP_LOOKUP, 4'd0, 32'h0000_1234, '0, 1'b0, '0));
		issue(make_command(OP_LOOKUP, 4'd0, '1, '0, 1'b0, '0));
		issue(make_command(OP_LOOKUP, 4'd0, 32'hDEAD_BEEF, '0, 1'b0, '0));
		issue(make_command(OP_SCAN, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_TICK, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_SCAN, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_RESUME, 4'd3, '0, '0, 1'b0, '0));
		issue(make_command(OP_RELOAD, 4'd2, '0, '0, 1'b0, '0));
		issue(make_command(OP_PAUSE, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_TICK, 4'd0, '0, '0, 1'b0, '0));
		issue(make_command(OP_SCAN, 4'd0, '0, '0, 1'b0, '0));
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Randomise every field; the opcode decides which of them matter
			c.op     = OP_TICK;
			c.sel    = SLOT_W'($urandom_range(0, MAX_TASKS - 1));
			c.cb     = $urandom();
			c.period = $urandom();
			c.en     = 1'($urandom_range(0, 1));
			c.phase  = PHASE_W'($urandom_range(0, 255));
			pick     = $urandom_range(0, 99);
			if (slot_table.used_count < MAX_TASKS && pick < 30) begin
				// Fill the table early, mostly with short periods so slots keep firing
				c.op = OP_ADD;
				if ($urandom_range(0, 9) < 8)
					c.period = $urandom_range(0, 9);
				if ($urandom_range(0, 9) < 8)
					c.en = 1'b1;
				if ($urandom_range(0, 1) == 0)
					c.phase = PHASE_W'($urandom_range(0, 12));
				if ($urandom_range(0, 3) == 0 && slot_table.used_count != 0)
					c.cb = slot_table.callback[$urandom_range(0, slot_table.used_count - 1)];
			end else if (pick < 5) begin
				c.op = OP_ADD;
			end else if (pick < 8) begin
				c.op = OP_UNDEFINED;
			end else if (pick < 45) begin
				c.op = OP_TICK;
			end else if (pick < 68) begin
				c.op = OP_SCAN;
			end else if (pick < 78) begin
				c.op = OP_LOOKUP;
				if ($urandom_range(0, 9) < 6 && slot_table.used_count != 0)
					c.cb = slot_table.callback[$urandom_range(0, slot_table.used_count - 1)];
			end else if (pick < 85) begin
				c.op = OP_RELOAD;
			end else if (pick < 91) begin
				c.op = OP_PAUSE;
			end else begin
				c.op = OP_RESUME;
			end
			issue(c);

			if (n == RANDOM_ITEMS / 2) begin
				drain();
			end else if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
				// Idle burst: either straight after the take, or once busy has dropped
				gap = $urandom_range(1, 4);
				start <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					while (busy !== 1'b0)
						@(negedge clk);
				repeat (gap) @(negedge clk);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (slot_table.mismatches == 0 && slot_table.due_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
